// File: hdl/bracket_record_decimal_field_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bracket record decimal field parser
// ----------------------------------------------------------------------------
`ifndef BRACKET_RECORD_DECIMAL_FIELD_PARSER_MACROS_SVH
`define BRACKET_RECORD_DECIMAL_FIELD_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BRDFP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BRDFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/brdfp_pkg.sv
// ----------------------------------------------------------------------------
// brdfp_pkg
// Shared types and constants of the bracket record decimal field parser.
// ----------------------------------------------------------------------------
package brdfp_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_VALUE_BITS  = 16;

    localparam int CH_W    = 8;
    localparam int FIELD_W = 4;

    localparam logic [CH_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CH_W-1:0] CH_COMMA   = 8'h2C;  // ','
    localparam logic [CH_W-1:0] CH_OPEN    = 8'h5B;  // '['
    localparam logic [CH_W-1:0] CH_CLOSE   = 8'h5D;  // ']'
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;  // '9'

    localparam logic [FIELD_W-1:0] FIELD_FIRST    = 4'd1;
    localparam logic [FIELD_W-1:0] FIELD_TELEPORT = 4'd9;
    localparam logic [FIELD_W-1:0] FIELD_DEST_X   = 4'd10;
    localparam logic [FIELD_W-1:0] FIELD_DEST_Y   = 4'd11;
    localparam logic [FIELD_W-1:0] FIELD_LAST     = 4'd13;
    localparam logic [FIELD_W-1:0] FIELD_CAP      = 4'd15;

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

endpackage

// File: hdl/bracket_record_decimal_field_parser.sv
// ----------------------------------------------------------------------------
// bracket_record_decimal_field_parser
// Parses '[' ... ']' cell records of comma-separated decimal fields.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one text byte per item on s_tdata[7:0].
//   m_ channel: one item per emitted field; tdata packs, from bit 0 up:
//     row, column, field_number, value. m_tlast marks field thirteen.
//   A newline byte advances the row and clears the column; ']' advances
//   the column. Field 9 is sent only when it is 1, fields 10 and 11 only
//   after field 9 was 1. Fields past thirteen and empty fields send nothing.
// Datapath: an accepted byte is held in the input register, then the parse
//   logic writes any result it gives into the result register.
// Throughput: one byte per cycle while results are taken; set by the parse
//   step (compare, multiply by ten and add).
// Reset: aresetn low clears both stages and the parse state (outside any
//   cell, row and column zero).
// Stall: while m_tready is low a waiting result holds; the input register
//   fills and then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module bracket_record_decimal_field_parser #(
    parameter int  MAX_COLUMNS = brdfp_pkg::DEF_MAX_COLUMNS,
    parameter int  MAX_ROWS    = brdfp_pkg::DEF_MAX_ROWS,
    parameter int  VALUE_BITS  = brdfp_pkg::DEF_VALUE_BITS,
    localparam int ROW_W       = $clog2(MAX_ROWS),
    localparam int COL_W       = $clog2(MAX_COLUMNS),
    localparam int OUT_BITS    = ROW_W + COL_W + brdfp_pkg::FIELD_W + VALUE_BITS,
    localparam int TDATA_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [brdfp_pkg::CH_W-1:0]     s_tdata,   // [7:0] ch
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [TDATA_W-1:0]             m_tdata,   // row, column, field_number, value, zero pad
    output logic                           m_tlast
);
    import brdfp_pkg::*;

    localparam int ACC_EXT_W = VALUE_BITS + 4;

    // input stage
    logic            in_valid_reg, in_valid_next;
    logic [CH_W-1:0] ch_reg;

    // parse state
    logic                  in_cell_reg, in_cell_next;
    logic [FIELD_W-1:0]    field_reg, field_next;
    phase_t                phase_reg, phase_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  teleport_reg, teleport_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;

    // result stage
    logic                  out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]      out_row_reg;
    logic [COL_W-1:0]      out_col_reg;
    logic [FIELD_W-1:0]    out_field_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_last_reg;

    logic                  s_accept, advance, emit, is_digit;
    logic [VALUE_BITS-1:0] digit_val;
    logic [ACC_EXT_W-1:0]  acc_times_ten, acc_sum;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign is_digit  = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign digit_val = VALUE_BITS'(ch_reg - CH_ZERO);
    // x*10 = x*8 + x*2
    assign acc_times_ten = (ACC_EXT_W'(acc_reg) << 3) + (ACC_EXT_W'(acc_reg) << 1);
    assign acc_sum       = acc_times_ten + ACC_EXT_W'(digit_val);

    always_comb begin
        in_cell_next  = in_cell_reg;
        field_next    = field_reg;
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        teleport_next = teleport_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        emit          = 1'b0;

        if (ch_reg == CH_NEWLINE) begin
            // abandons any open cell
            in_cell_next = 1'b0;
            phase_next   = PH_WAIT;
            acc_next     = '0;
            col_next     = '0;
            if (row_reg < ROW_W'(MAX_ROWS - 1)) begin
                row_next = row_reg + 1'b1;
            end
        end else if (!in_cell_reg) begin
            if (ch_reg == CH_OPEN) begin
                in_cell_next  = 1'b1;
                field_next    = FIELD_FIRST;
                phase_next    = PH_WAIT;
                acc_next      = '0;
                teleport_next = 1'b0;
            end
        end else if (is_digit) begin
            unique case (phase_reg)
                PH_WAIT: begin
                    phase_next = PH_DIGITS;
                    acc_next   = digit_val;
                end
                PH_DIGITS: begin
                    if (acc_sum > ACC_EXT_W'({VALUE_BITS{1'b1}})) begin
                        acc_next = '1;
                    end else begin
                        acc_next = acc_sum[VALUE_BITS-1:0];
                    end
                end
                default: begin
                    // digits after a finished field are dropped
                end
            endcase
        end else begin
            if (phase_reg == PH_DIGITS) begin
                phase_next = PH_DONE;
                if (field_reg == FIELD_TELEPORT) begin
                    teleport_next = (acc_reg == VALUE_BITS'(1));
                    emit          = (acc_reg == VALUE_BITS'(1));
                end else if (field_reg == FIELD_DEST_X || field_reg == FIELD_DEST_Y) begin
                    emit = teleport_reg;
                end else begin
                    emit = (field_reg >= FIELD_FIRST) && (field_reg <= FIELD_LAST);
                end
            end
            if (ch_reg == CH_COMMA) begin
                if (field_reg < FIELD_CAP) begin
                    field_next = field_reg + 1'b1;
                end
                phase_next = PH_WAIT;
                acc_next   = '0;
            end else if (ch_reg == CH_CLOSE) begin
                in_cell_next = 1'b0;
                phase_next   = PH_WAIT;
                acc_next     = '0;
                if (col_reg < COL_W'(MAX_COLUMNS - 1)) begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        if (advance) begin
            out_valid_next = emit;
        end else begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_cell_reg   <= 1'b0;
            field_reg     <= FIELD_FIRST;
            phase_reg     <= PH_WAIT;
            acc_reg       <= '0;
            teleport_reg  <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                in_cell_reg  <= in_cell_next;
                field_reg    <= field_next;
                phase_reg    <= phase_next;
                acc_reg      <= acc_next;
                teleport_reg <= teleport_next;
                col_reg      <= col_next;
                row_reg      <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ch_reg <= s_tdata;
        end
        if (advance && emit) begin
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
            out_field_reg <= field_reg;
            out_value_reg <= acc_reg;
            out_last_reg  <= (field_reg == FIELD_LAST);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = TDATA_W'({out_value_reg, out_field_reg, out_col_reg, out_row_reg});

endmodule

// File: hdl/brdfp_checker.sv
// ----------------------------------------------------------------------------
// brdfp_checker
// Port-level checks on the stream channels of the field parser.
// ----------------------------------------------------------------------------
`include "bracket_record_decimal_field_parser_macros.svh"

module brdfp_checker #(
    parameter int ROW_W      = 6,
    parameter int COL_W      = 6,
    parameter int TDATA_W    = 32
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [brdfp_pkg::CH_W-1:0] s_tdata,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [TDATA_W-1:0]         m_tdata,
    input logic                       m_tlast
);
    import brdfp_pkg::*;

    localparam int FN_LO = ROW_W + COL_W;

    logic [FIELD_W-1:0] fn;

    assign fn = m_tdata[FN_LO +: FIELD_W];

    `BRDFP_ASSERT_NEXT(a_in_hold_on_stall, aclk, aresetn, s_tvalid && !s_tready,
        s_tvalid && $stable(s_tdata), "input item changed while waiting")

    `BRDFP_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    `BRDFP_ASSERT_NOW(a_last_is_thirteen, aclk, aresetn, m_tvalid,
        m_tlast == (fn == FIELD_LAST), "tlast does not match field thirteen")

    `BRDFP_ASSERT_NOW(a_field_range, aclk, aresetn, m_tvalid,
        (fn >= FIELD_FIRST) && (fn <= FIELD_LAST), "field number out of range")

endmodule

bind bracket_record_decimal_field_parser brdfp_checker #(
    .ROW_W      (ROW_W),
    .COL_W      (COL_W),
    .TDATA_W    (TDATA_W)
) u_brdfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
